// ----- design/tgm_pkg.sv -----
package tgm_pkg;

  // default sizes
  localparam int FINGERS_DEF = 3;
  localparam int ID_BITS_DEF = 16;
  localparam int COORD_FRAC_BITS_DEF = 16;

  // register reset values
  localparam logic [15:0] TAP_TIME_RST = 16'd250;
  localparam logic [7:0] TAP_RADIUS_RST = 8'd10;
  localparam logic [15:0] CLICK_HOLD_RST = 16'd50;
  localparam logic [11:0] SCREEN_W_RST = 12'd1280;
  localparam logic [11:0] SCREEN_H_RST = 12'd720;

  // sub-pixel steps per pixel, as a shift
  localparam int SUBPIX_SHIFT = 4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_HOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd4;

  // request codes
  localparam logic [1:0] REQ_DOWN = 2'd0;
  localparam logic [1:0] REQ_UP = 2'd1;
  localparam logic [1:0] REQ_MOTION = 2'd2;
  localparam logic [1:0] REQ_TICK = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_PRESS = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_MOVE = 2'd3;

  // drag modes
  localparam logic [1:0] DRAG_OFF = 2'd0;
  localparam logic [1:0] DRAG_LEFT = 2'd1;
  localparam logic [1:0] DRAG_RIGHT = 2'd2;

  localparam int OUT_W = 72;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STAGE1,
    ST_STAGE2,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic btn;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] rel_x;
    logic signed [15:0] rel_y;
    logic last;
  } res_t;

  typedef struct packed {
    logic load;
    logic stage1;
    logic stage2;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic [1:0] count;
  } status_t;

endpackage

// ----- design/touch_gesture_to_mouse_top.sv -----
// the input transfer latches the item, which then passes scan, square and commit;
//   the first result is valid once commit has written the result buffer
// throughput: sequential; the next item is taken only once the result buffer
//   is empty, so receiver stalls also hold off the next input
// reset: synchronous active-high rst empties the finger table, drag state, pending
//   clicks, sub-pixel sums and result buffer, and loads the register defaults
module touch_gesture_to_mouse_top #(
  parameter int FINGERS = tgm_pkg::FINGERS_DEF,
  parameter int ID_BITS = tgm_pkg::ID_BITS_DEF,
  parameter int COORD_FRAC_BITS = tgm_pkg::COORD_FRAC_BITS_DEF,
  parameter int IN_W = ((ID_BITS + 4 * COORD_FRAC_BITS + 68 + 7) / 8) * 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // finger_id, time_ms, touch_x, touch_y, delta_x, delta_y, pointer_x, pointer_y
  input  logic [IN_W-1:0] s_tdata,
  // req_type
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // mouse_button, pos_x, pos_y, rel_x, rel_y
  output logic [tgm_pkg::OUT_W-1:0] m_tdata,
  // result_kind
  output logic [1:0] m_tuser,
  output logic m_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [tgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tgm_pkg::*;

  cmd_t cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  tgm_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .st(st),
    .cmd(cmd)
  );

  tgm_datapath #(
    .FINGERS(FINGERS),
    .ID_BITS(ID_BITS),
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .IN_W(IN_W)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .st(st),
    .in_data(s_tdata),
    .in_user(s_tuser),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data(m_tdata),
    .out_user(m_tuser),
    .out_last(m_tlast)
  );

  // input taken only with the result buffer empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> st.empty) else $error("input ready with results pending");

  // an accepted item blocks the input for the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("input ready while busy");

  // the buffer holds at most two results
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    st.count != 2'd3) else $error("result buffer overflow");

  // a first of two results is not marked final
  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && st.count == 2'd2) |-> !m_tlast) else $error("early last");

endmodule

// ----- design/tgm_ctrl.sv -----
module tgm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  tgm_pkg::status_t st,
  output tgm_pkg::cmd_t cmd
);
  import tgm_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = st.empty;
        if (s_tvalid && st.empty) begin
          cmd.load = 1'b1;
          state_next = ST_STAGE1;
        end
      end
      ST_STAGE1: begin
        cmd.stage1 = 1'b1;
        state_next = ST_STAGE2;
      end
      ST_STAGE2: begin
        cmd.stage2 = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- design/tgm_datapath.sv -----
module tgm_datapath #(
  parameter int FINGERS = tgm_pkg::FINGERS_DEF,
  parameter int ID_BITS = tgm_pkg::ID_BITS_DEF,
  parameter int COORD_FRAC_BITS = tgm_pkg::COORD_FRAC_BITS_DEF,
  parameter int IN_W = 152
) (
  input  logic clk,
  input  logic rst,
  input  tgm_pkg::cmd_t cmd,
  output tgm_pkg::status_t st,
  input  logic [IN_W-1:0] in_data,
  input  logic [1:0] in_user,
  input  logic cfg_valid,
  input  logic [tgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic out_valid,
  input  logic out_ready,
  output logic [tgm_pkg::OUT_W-1:0] out_data,
  output logic [1:0] out_user,
  output logic out_last
);
  import tgm_pkg::*;

  localparam int F = COORD_FRAC_BITS;
  localparam int DW = F + 2;
  localparam int RW = F + 8;
  localparam int AW = F + 12;
  localparam int MW = F + 15;
  localparam int SW = 19;
  localparam int HW = SW + 1;
  localparam int CW = $clog2(FINGERS + 1);
  localparam int IW = $clog2(FINGERS);
  localparam int O_T = ID_BITS;
  localparam int O_TX = O_T + 32;
  localparam int O_TY = O_TX + F;
  localparam int O_DX = O_TY + F;
  localparam int O_DY = O_DX + DW;
  localparam int O_PX = O_DY + DW;
  localparam int O_PY = O_PX + 16;

  // configuration registers
  logic [15:0] tap_time;
  logic [7:0] tap_radius;
  logic [15:0] click_hold;
  logic [11:0] screen_w;
  logic [11:0] screen_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_time <= TAP_TIME_RST;
      tap_radius <= TAP_RADIUS_RST;
      click_hold <= CLICK_HOLD_RST;
      screen_w <= SCREEN_W_RST;
      screen_h <= SCREEN_H_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TAP_TIME: tap_time <= cfg_data;
        REG_TAP_RADIUS: tap_radius <= cfg_data[7:0];
        REG_CLICK_HOLD: click_hold <= cfg_data;
        REG_SCREEN_W: screen_w <= cfg_data[11:0];
        REG_SCREEN_H: screen_h <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // latched input item
  logic [1:0] req;
  logic [ID_BITS-1:0] id;
  logic [31:0] now;
  logic [F-1:0] tx, ty;
  logic signed [DW-1:0] ddx, ddy;
  logic signed [15:0] px, py;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_user;
      id <= in_data[ID_BITS-1:0];
      now <= in_data[O_TX-1:O_T];
      tx <= in_data[O_TY-1:O_TX];
      ty <= in_data[O_DX-1:O_TY];
      ddx <= in_data[O_DY-1:O_DX];
      ddy <= in_data[O_PX-1:O_DY];
      px <= in_data[O_PY-1:O_PX];
      py <= in_data[O_PY+15:O_PY];
    end
  end

  // finger table and gesture state
  logic [FINGERS-1:0] slot_valid;
  logic [ID_BITS-1:0] slot_finger [FINGERS];
  logic [31:0] slot_down_time [FINGERS];
  logic [F-1:0] slot_down_x [FINGERS];
  logic [F-1:0] slot_down_y [FINGERS];
  logic [1:0] drag_mode;
  logic [1:0] click_pending;
  logic [31:0] click_start [2];
  logic signed [4:0] subpixel_x, subpixel_y;

  // stage 1: table scan and first products
  logic [FINGERS-1:0] match;
  logic [CW-1:0] down_c, long_c;
  logic oldest_c;
  logic [31:0] sel_time;
  logic [F-1:0] sel_x, sel_y;
  logic signed [F:0] dx, dy;
  logic [F-1:0] adx, ady;

  always_comb begin
    down_c = '0;
    long_c = '0;
    oldest_c = 1'b1;
    sel_time = '0;
    sel_x = '0;
    sel_y = '0;
    for (int i = 0; i < FINGERS; i++) begin
      match[i] = slot_valid[i] && (slot_finger[i] == id);
      if (slot_valid[i]) down_c = down_c + 1'b1;
      if (slot_valid[i] && ((now - slot_down_time[i]) > {16'd0, tap_time}))
        long_c = long_c + 1'b1;
    end
    for (int i = FINGERS - 1; i >= 0; i--) begin
      if (match[i]) begin
        sel_time = slot_down_time[i];
        sel_x = slot_down_x[i];
        sel_y = slot_down_y[i];
      end
    end
    // oldest test only matters with more than one finger down
    if (down_c > 1) begin
      for (int i = 0; i < FINGERS; i++)
        for (int j = 0; j < FINGERS; j++)
          if (match[i] && j != i && slot_valid[j] && slot_down_time[j] < slot_down_time[i])
            oldest_c = 1'b0;
    end
    dx = $signed({1'b0, tx}) - $signed({1'b0, sel_x});
    dy = $signed({1'b0, ty}) - $signed({1'b0, sel_y});
    adx = dx[F] ? F'(-dx) : dx[F-1:0];
    ady = dy[F] ? F'(-dy) : dy[F-1:0];
  end

  logic [FINGERS-1:0] s1_match;
  logic [CW-1:0] s1_down, s1_long;
  logic s1_oldest, s1_tap_time_ok;
  logic [AW-1:0] s1_a, s1_b;
  logic [RW-1:0] s1_r;
  logic signed [MW-1:0] s1_mx, s1_my;

  always_ff @(posedge clk) begin
    if (cmd.stage1) begin
      s1_match <= match;
      s1_down <= down_c;
      s1_long <= long_c;
      s1_oldest <= oldest_c;
      s1_tap_time_ok <= (now - sel_time) <= {16'd0, tap_time};
      s1_a <= AW'(adx) * AW'(screen_w);
      s1_b <= AW'(ady) * AW'(screen_h);
      s1_r <= {tap_radius, {F{1'b0}}};
      s1_mx <= MW'(ddx) * MW'($signed({1'b0, screen_w}));
      s1_my <= MW'(ddy) * MW'($signed({1'b0, screen_h}));
    end
  end

  // stage 2: squares and scaled pointer steps
  logic [MW-1:0] mabs_x, mabs_y, msh_x, msh_y;
  logic signed [SW-1:0] step_x_c, step_y_c;

  always_comb begin
    mabs_x = s1_mx[MW-1] ? MW'(-s1_mx) : MW'(s1_mx);
    mabs_y = s1_my[MW-1] ? MW'(-s1_my) : MW'(s1_my);
    msh_x = mabs_x >> (F - SUBPIX_SHIFT);
    msh_y = mabs_y >> (F - SUBPIX_SHIFT);
    step_x_c = s1_mx[MW-1] ? SW'(-msh_x[SW-1:0]) : msh_x[SW-1:0];
    step_y_c = s1_my[MW-1] ? SW'(-msh_y[SW-1:0]) : msh_y[SW-1:0];
  end

  logic s2_a_ge, s2_b_ge;
  logic [2*RW-1:0] s2_a2, s2_b2, s2_rr;
  logic signed [SW-1:0] s2_step_x, s2_step_y;

  always_ff @(posedge clk) begin
    if (cmd.stage2) begin
      s2_a_ge <= s1_a >= AW'(s1_r);
      s2_b_ge <= s1_b >= AW'(s1_r);
      s2_a2 <= s1_a[RW-1:0] * s1_a[RW-1:0];
      s2_b2 <= s1_b[RW-1:0] * s1_b[RW-1:0];
      s2_rr <= s1_r * s1_r;
      s2_step_x <= step_x_c;
      s2_step_y <= step_y_c;
    end
  end

  // commit: gesture decisions and state updates
  logic small_travel;
  logic [2*RW:0] sq_sum;
  logic signed [HW-1:0] hx, hy, rx, ry;
  logic [HW-1:0] hax, hay;
  logic [FINGERS-1:0] valid_next, vclr;
  logic [1:0] drag_next, pending_next;
  logic [1:0] start_we;
  logic signed [4:0] subx_next, suby_next;
  logic sub_we, ins_we;
  logic [IW-1:0] ins_idx;
  logic ev0_v, ev1_v;
  res_t ev0, ev1, none_res;
  logic hit, btn_c;

  always_comb begin
    sq_sum = {1'b0, s2_a2} + {1'b0, s2_b2};
    small_travel = !s2_a_ge && !s2_b_ge && (sq_sum < {1'b0, s2_rr});
    hx = HW'(subpixel_x) + HW'(s2_step_x);
    hy = HW'(subpixel_y) + HW'(s2_step_y);
    hax = hx[HW-1] ? HW'(-hx) : HW'(hx);
    hay = hy[HW-1] ? HW'(-hy) : HW'(hy);
    rx = hx[HW-1] ? HW'(-(hax >> SUBPIX_SHIFT)) : HW'(hax >> SUBPIX_SHIFT);
    ry = hy[HW-1] ? HW'(-(hay >> SUBPIX_SHIFT)) : HW'(hay >> SUBPIX_SHIFT);
    hit = |s1_match;
    btn_c = 1'b0;
    valid_next = slot_valid;
    vclr = slot_valid & ~s1_match;
    drag_next = drag_mode;
    pending_next = click_pending;
    start_we = '0;
    subx_next = subpixel_x;
    suby_next = subpixel_y;
    sub_we = 1'b0;
    ins_we = 1'b0;
    ins_idx = '0;
    ev0_v = 1'b0;
    ev1_v = 1'b0;
    ev0 = '0;
    ev1 = '0;
    none_res = '0;
    none_res.last = 1'b1;
    case (req)
      REQ_DOWN: begin
        for (int i = FINGERS - 1; i >= 0; i--) begin
          if (!vclr[i]) begin
            ins_idx = IW'(i);
            ins_we = 1'b1;
          end
        end
        valid_next = vclr;
        if (ins_we) valid_next[ins_idx] = 1'b1;
      end
      REQ_UP: begin
        if (hit) begin
          valid_next = vclr;
          if (drag_mode == DRAG_OFF) begin
            if (s1_tap_time_ok && small_travel &&
                (s1_down == CW'(1) || s1_down == CW'(2))) begin
              btn_c = s1_down == CW'(2);
              pending_next[btn_c] = 1'b1;
              start_we[btn_c] = 1'b1;
              ev0_v = 1'b1;
              ev0.kind = KIND_PRESS;
              ev0.btn = btn_c;
              ev0.pos_x = px;
              ev0.pos_y = py;
            end
          end else if (s1_down == CW'(1)) begin
            ev0_v = 1'b1;
            ev0.kind = KIND_RELEASE;
            ev0.btn = drag_mode == DRAG_RIGHT;
            ev0.pos_x = px;
            ev0.pos_y = py;
            drag_next = DRAG_OFF;
          end
        end
      end
      REQ_MOTION: begin
        if (s1_down >= CW'(1)) begin
          if (s1_down >= CW'(2) && drag_mode == DRAG_OFF && s1_long >= CW'(2)) begin
            ev0_v = 1'b1;
            ev0.kind = KIND_PRESS;
            ev0.btn = s1_long != CW'(2);
            ev0.pos_x = px;
            ev0.pos_y = py;
            drag_next = (s1_long == CW'(2)) ? DRAG_LEFT : DRAG_RIGHT;
          end
          if (s1_oldest) begin
            sub_we = 1'b1;
            subx_next = 5'(hx - (rx <<< SUBPIX_SHIFT));
            suby_next = 5'(hy - (ry <<< SUBPIX_SHIFT));
            if (rx != '0 || ry != '0) begin
              ev1_v = 1'b1;
              ev1.kind = KIND_MOVE;
              ev1.pos_x = px + 16'(rx);
              ev1.pos_y = py + 16'(ry);
              ev1.rel_x = 16'(rx);
              ev1.rel_y = 16'(ry);
            end
          end
        end
      end
      REQ_TICK: begin
        if (click_pending[0] && (now - click_start[0]) >= {16'd0, click_hold}) begin
          ev0_v = 1'b1;
          ev0.kind = KIND_RELEASE;
          ev0.pos_x = px;
          ev0.pos_y = py;
          pending_next[0] = 1'b0;
        end
        if (click_pending[1] && (now - click_start[1]) >= {16'd0, click_hold}) begin
          ev1_v = 1'b1;
          ev1.kind = KIND_RELEASE;
          ev1.btn = 1'b1;
          ev1.pos_x = px;
          ev1.pos_y = py;
          pending_next[1] = 1'b0;
        end
      end
      default: ;
    endcase
    // the second event is always final, the first only when alone
    ev0.last = !ev1_v;
    ev1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      drag_mode <= DRAG_OFF;
      click_pending <= '0;
      subpixel_x <= '0;
      subpixel_y <= '0;
    end else if (cmd.commit) begin
      slot_valid <= valid_next;
      drag_mode <= drag_next;
      click_pending <= pending_next;
      if (sub_we) begin
        subpixel_x <= subx_next;
        subpixel_y <= suby_next;
      end
    end
  end

  // table payload and click start times
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < FINGERS; i++) begin
        if (ins_we && ins_idx == IW'(i)) begin
          slot_finger[i] <= id;
          slot_down_time[i] <= now;
          slot_down_x[i] <= tx;
          slot_down_y[i] <= ty;
        end
      end
      for (int b = 0; b < 2; b++)
        if (start_we[b]) click_start[b] <= now;
    end
  end

  // two-entry result buffer, head in entry 0
  res_t buf0, buf1;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= (ev0_v && ev1_v) ? 2'd2 : 2'd1;
    end else if (out_valid && out_ready) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (ev0_v) begin
        buf0 <= ev0;
        buf1 <= ev1;
      end else if (ev1_v) begin
        buf0 <= ev1;
      end else begin
        buf0 <= none_res;
      end
    end else if (out_valid && out_ready) begin
      buf0 <= buf1;
    end
  end

  assign out_valid = count != 2'd0;
  assign out_user = buf0.kind;
  assign out_last = buf0.last;
  assign out_data = {7'd0, buf0.rel_y, buf0.rel_x, buf0.pos_y, buf0.pos_x, buf0.btn};
  assign st.empty = count == 2'd0;
  assign st.count = count;

endmodule
